>>> src/checked_integer_alu_macros.svh
// Assertion macros for the checked integer ALU.
// Taken in by every RTL file that asserts; needs a clk and rst_n in scope.
`ifndef CHECKED_INTEGER_ALU_MACROS_SVH
`define CHECKED_INTEGER_ALU_MACROS_SVH
`ifndef SYNTHESIS
`define CIA_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("checked_integer_alu: same-cycle check failed");
`define CIA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checked_integer_alu: next-cycle check failed");
`else
`define CIA_ASSERT_IMPLY(lbl, ante, cons)
`define CIA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> src/cia_pkg.sv
// Package for the checked integer ALU: codes, beat structs and width helpers.
// No dependencies; used by cia_div_stage and checked_integer_alu.
package cia_pkg;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    localparam logic [1:0] W8  = 2'd0;
    localparam logic [1:0] W16 = 2'd1;
    localparam logic [1:0] W32 = 2'd2;
    localparam logic [1:0] W64 = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam int DIV_STEPS = 64;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] wcode;
        logic       sgn;
        logic       neg;
    } ctl_t;

    // Beat carried through the divider stages
    typedef struct packed {
        ctl_t        ctl;
        logic [63:0] as_res;
        logic        as_ovf;
        logic [63:0] mul_lo;
        logic [63:0] mul_hi;
        logic [63:0] mb;
        logic [63:0] rem;
        logic [63:0] dq;
    } div_t;

    function automatic logic [63:0] width_mask(input logic [1:0] wcode);
        logic [63:0] m;
        unique case (wcode)
            W8:      m = 64'h0000_0000_0000_00FF;
            W16:     m = 64'h0000_0000_0000_FFFF;
            W32:     m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] sext(input logic [63:0] x, input logic [1:0] wcode);
        logic [63:0] r;
        unique case (wcode)
            W8:      r = {{56{x[7]}}, x[7:0]};
            W16:     r = {{48{x[15]}}, x[15:0]};
            W32:     r = {{32{x[31]}}, x[31:0]};
            default: r = x;
        endcase
        return r;
    endfunction

    // Magnitude of the most negative value at each width
    function automatic logic [63:0] neg_limit(input logic [1:0] wcode);
        logic [63:0] l;
        unique case (wcode)
            W8:      l = 64'h0000_0000_0000_0080;
            W16:     l = 64'h0000_0000_0000_8000;
            W32:     l = 64'h0000_0000_8000_0000;
            default: l = 64'h8000_0000_0000_0000;
        endcase
        return l;
    endfunction

endpackage

>>> src/cia_div_stage.sv
// One registered step of the restoring divider, one quotient bit per stage.
// Depends on cia_pkg for the div_t beat struct.
module cia_div_stage (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  cia_pkg::div_t in_item,
    output logic         out_valid,
    output cia_pkg::div_t out_item
);

    logic           valid_reg;
    cia_pkg::div_t  item_reg;
    cia_pkg::div_t  item_next;
    logic [64:0]    rem_sh;
    logic [64:0]    diff;
    logic           ge;

    // Shift in the next dividend bit, subtract the divisor if it fits
    always_comb
    begin
        rem_sh    = {in_item.rem, in_item.dq[63]};
        diff      = rem_sh - {1'b0, in_item.mb};
        ge        = rem_sh >= {1'b0, in_item.mb};
        item_next = in_item;
        item_next.rem = ge ? diff[63:0] : rem_sh[63:0];
        item_next.dq  = {in_item.dq[62:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> src/checked_integer_alu.sv
// Checked integer ALU top level: add, subtract, multiply, divide with overflow status.
// Depends on cia_pkg, cia_div_stage and checked_integer_alu_macros.svh.
//
// One beat in, one beat out, in order. The block takes a new beat every cycle
// while the output is not stalled. Each beat passes through five front stages
// (operand extension, magnitudes and add/subtract, 32x32 partial products,
// middle sum, 128-bit product), then 64 divider stages of one quotient bit
// each, then the status and result stage. The divider depth sets the latency.
// A stall on the output holds the whole pipeline; tready on the input follows.
// On overflow or divide by zero the result is zero.
`include "checked_integer_alu_macros.svh"
module checked_integer_alu (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // left_operand[63:0], right_operand[127:64]
    input  logic [4:0]   s_axis_tuser,  // cmd[1:0], width_code[3:2], signed_mode[4]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // result_value[63:0]
    output logic [1:0]   m_axis_tuser   // status[1:0]
);

    localparam int NDIV = cia_pkg::DIV_STEPS;

    logic en;
    logic [4:0] v_reg;

    // Stage 0 registers
    cia_pkg::ctl_t c0_reg;
    logic [63:0]   a0_reg, b0_reg;
    // Stage 1 registers
    cia_pkg::ctl_t c1_reg;
    logic [63:0]   as1_reg, ma1_reg, mb1_reg;
    logic          ovf1_reg;
    // Stage 2 registers
    cia_pkg::ctl_t c2_reg;
    logic [63:0]   as2_reg, ma2_reg, mb2_reg;
    logic          ovf2_reg;
    logic [63:0]   pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    // Stage 3 registers
    cia_pkg::ctl_t c3_reg;
    logic [63:0]   as3_reg, ma3_reg, mb3_reg;
    logic          ovf3_reg;
    logic [63:0]   pp00_3_reg, pp11_3_reg;
    logic [64:0]   mid_reg;
    // Stage 4 register
    cia_pkg::div_t d4_reg;
    // Output register
    logic          out_valid_reg;
    logic [63:0]   res_reg;
    logic [1:0]    st_reg;
    logic [1:0]    wc_reg;
    logic [1:0]    cmd_reg;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], s_axis_tvalid};
        end
    end

    // Stage 0: mask and extend operands
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_reg.cmd   <= s_axis_tuser[1:0];
            c0_reg.wcode <= s_axis_tuser[3:2];
            c0_reg.sgn   <= s_axis_tuser[4];
            c0_reg.neg   <= 1'b0;
            a0_reg <= s_axis_tuser[4] ? cia_pkg::sext(s_axis_tdata[63:0], s_axis_tuser[3:2])
                    : (s_axis_tdata[63:0] & cia_pkg::width_mask(s_axis_tuser[3:2]));
            b0_reg <= s_axis_tuser[4] ? cia_pkg::sext(s_axis_tdata[127:64], s_axis_tuser[3:2])
                    : (s_axis_tdata[127:64] & cia_pkg::width_mask(s_axis_tuser[3:2]));
        end
    end

    // Stage 1: add/subtract with overflow, operand magnitudes
    logic [64:0] sum65, dif65;
    logic [63:0] as_r, m0, ma_next, mb_next;
    logic        as_ovf_next;
    always_comb
    begin
        sum65 = {1'b0, a0_reg} + {1'b0, b0_reg};
        dif65 = {1'b0, a0_reg} - {1'b0, b0_reg};
        m0    = cia_pkg::width_mask(c0_reg.wcode);
        as_r  = (c0_reg.cmd == cia_pkg::CMD_ADD) ? sum65[63:0] : dif65[63:0];
        if (!c0_reg.sgn)
        begin
            as_ovf_next = (c0_reg.cmd == cia_pkg::CMD_ADD)
                        ? (sum65[64] || ((sum65[63:0] & ~m0) != '0)) : dif65[64];
        end
        else if (c0_reg.wcode == cia_pkg::W64)
        begin
            as_ovf_next = (c0_reg.cmd == cia_pkg::CMD_ADD)
                        ? (((a0_reg ^ as_r) & (b0_reg ^ as_r)) >> 63) != '0
                        : (((a0_reg ^ b0_reg) & (a0_reg ^ as_r)) >> 63) != '0;
        end
        else
        begin
            as_ovf_next = cia_pkg::sext(as_r, c0_reg.wcode) != as_r;
        end
        ma_next = (c0_reg.sgn && a0_reg[63]) ? (64'd0 - a0_reg) : a0_reg;
        mb_next = (c0_reg.sgn && b0_reg[63]) ? (64'd0 - b0_reg) : b0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg.cmd   <= c0_reg.cmd;
            c1_reg.wcode <= c0_reg.wcode;
            c1_reg.sgn   <= c0_reg.sgn;
            c1_reg.neg   <= c0_reg.sgn && (a0_reg[63] ^ b0_reg[63]);
            as1_reg      <= as_r;
            ovf1_reg     <= as_ovf_next;
            ma1_reg      <= ma_next;
            mb1_reg      <= mb_next;
        end
    end

    // Stage 2: four 32x32 partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_reg   <= c1_reg;
            as2_reg  <= as1_reg;
            ovf2_reg <= ovf1_reg;
            ma2_reg  <= ma1_reg;
            mb2_reg  <= mb1_reg;
            pp00_reg <= ma1_reg[31:0]  * mb1_reg[31:0];
            pp01_reg <= ma1_reg[31:0]  * mb1_reg[63:32];
            pp10_reg <= ma1_reg[63:32] * mb1_reg[31:0];
            pp11_reg <= ma1_reg[63:32] * mb1_reg[63:32];
        end
    end

    // Stage 3: sum the cross products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c3_reg     <= c2_reg;
            as3_reg    <= as2_reg;
            ovf3_reg   <= ovf2_reg;
            ma3_reg    <= ma2_reg;
            mb3_reg    <= mb2_reg;
            pp00_3_reg <= pp00_reg;
            pp11_3_reg <= pp11_reg;
            mid_reg    <= {1'b0, pp01_reg} + {1'b0, pp10_reg};
        end
    end

    // Stage 4: full product, seed the divider
    logic [127:0] prod;
    assign prod = {pp11_3_reg, pp00_3_reg} + {31'd0, mid_reg, 32'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d4_reg.ctl    <= c3_reg;
            d4_reg.as_res <= as3_reg;
            d4_reg.as_ovf <= ovf3_reg;
            d4_reg.mul_lo <= prod[63:0];
            d4_reg.mul_hi <= prod[127:64];
            d4_reg.mb     <= mb3_reg;
            d4_reg.rem    <= '0;
            d4_reg.dq     <= ma3_reg;
        end
    end

    // Divider stages
    cia_pkg::div_t dv_item [NDIV+1];
    logic          dv_valid [NDIV+1];
    assign dv_item[0]  = d4_reg;
    assign dv_valid[0] = v_reg[4];

    for (genvar k = 0; k < NDIV; k++)
    begin : g_div
        cia_div_stage u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_valid[k]),
            .in_item   (dv_item[k]),
            .out_valid (dv_valid[k+1]),
            .out_item  (dv_item[k+1])
        );
    end

    // Final stage: range check, sign, mask
    cia_pkg::div_t fin;
    logic [63:0]   mf, mr, sres, res_next;
    logic          hi_nz, fits;
    logic [1:0]    st_next;
    always_comb
    begin
        fin   = dv_item[NDIV];
        mf    = cia_pkg::width_mask(fin.ctl.wcode);
        hi_nz = fin.mul_hi != '0;
        mr    = (fin.ctl.cmd == cia_pkg::CMD_MUL) ? fin.mul_lo : fin.dq;
        fits  = fin.ctl.neg ? (mr <= cia_pkg::neg_limit(fin.ctl.wcode))
                            : (mr <  cia_pkg::neg_limit(fin.ctl.wcode));
        sres  = fin.ctl.neg ? (64'd0 - mr) : mr;
        st_next  = cia_pkg::ST_OK;
        res_next = '0;
        unique case (fin.ctl.cmd)
            cia_pkg::CMD_ADD, cia_pkg::CMD_SUB:
            begin
                st_next  = fin.as_ovf ? cia_pkg::ST_OVF : cia_pkg::ST_OK;
                res_next = fin.as_res;
            end
            cia_pkg::CMD_MUL:
            begin
                if (!fin.ctl.sgn)
                begin
                    st_next  = (hi_nz || ((fin.mul_lo & ~mf) != '0)) ? cia_pkg::ST_OVF
                             : cia_pkg::ST_OK;
                    res_next = fin.mul_lo;
                end
                else
                begin
                    st_next  = (hi_nz || !fits) ? cia_pkg::ST_OVF : cia_pkg::ST_OK;
                    res_next = sres;
                end
            end
            default:
            begin
                if (fin.mb == '0)
                begin
                    st_next = cia_pkg::ST_DIV0;
                end
                else if (fin.ctl.sgn && !fits)
                begin
                    st_next = cia_pkg::ST_OVF;
                end
                res_next = fin.ctl.sgn ? sres : fin.dq;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid[NDIV];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= (st_next == cia_pkg::ST_OK) ? (res_next & mf) : '0;
            st_reg  <= st_next;
            wc_reg  <= fin.ctl.wcode;
            cmd_reg <= fin.ctl.cmd;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = res_reg;
    assign m_axis_tuser  = st_reg;

    `CIA_ASSERT_IMPLY(a_fail_zero, out_valid_reg && (st_reg != cia_pkg::ST_OK), res_reg == '0)
    `CIA_ASSERT_IMPLY(a_div0_cmd, out_valid_reg && (st_reg == cia_pkg::ST_DIV0), cmd_reg == cia_pkg::CMD_DIV)
    `CIA_ASSERT_IMPLY(a_w8_upper, out_valid_reg && (wc_reg == cia_pkg::W8), res_reg[63:8] == '0)
    `CIA_ASSERT_NEXT(a_enter, s_axis_tvalid && s_axis_tready, v_reg[0])

endmodule
